// ----- hdl/nupw_pkg.sv -----
// Shared types and constants for the nearest unvisited point walk.
package nupw_pkg;

  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned IdxW       = $clog2(MaxPoints);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned CoordW     = 11;
  localparam int unsigned PenW       = 8;
  localparam int unsigned LimW       = 14;
  localparam int unsigned DistW      = 12;
  localparam int unsigned SumW       = 2 * CoordW + 1;
  localparam int unsigned RootW      = SumW + 1;
  localparam int unsigned SqrtSteps  = (SumW + 1) / 2;
  localparam int unsigned StepW      = $clog2(SqrtSteps + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 14;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgPointCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPenalty    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLimit      = 2'd2;

  localparam logic [CntW-1:0] RstPointCount = CntW'(1024);
  localparam logic [PenW-1:0] RstPenalty    = PenW'(5);
  localparam logic [LimW-1:0] RstLimit      = LimW'(10000);

  // action codes
  localparam logic [1:0] ActLoad    = 2'd0;
  localparam logic [1:0] ActStart   = 2'd1;
  localparam logic [1:0] ActAdvance = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IdxW-1:0]   slot;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   chosen_index;
    logic [CoordW-1:0] chosen_x;
    logic [CoordW-1:0] chosen_y;
    logic [DistW-1:0]  chosen_distance;
  } out_t;

endpackage

// ----- hdl/nearest_unvisited_point_walk.sv -----
// Top level of the nearest unvisited point walk: point table, visited map, scan sequencer.
//
//  channel   direction  handshake                    payload
//  command   in         start_i, busy_o              in_i   (nupw_pkg::in_t)
//  result    out        res_valid_o (one-cycle beat) res_o  (nupw_pkg::out_t)
//  config    in         cfg_valid_i, cfg_ready_o     cfg_index_i, cfg_data_i
//
// Load and ignored beats leave the block idle. A start beat moves the head and then sweeps
// the visited map clear, one entry a cycle; the same sweep runs after reset. An advance
// beat visits each of the point_count entries (at most MaxPoints) in turn: a visited entry
// passes read and square, an unvisited one read, square, 12 square-root steps on the one
// shared unit and compare; a final state then reports the result.
// The result beat is on res_o for one cycle only; the receiver cannot stall it.
module nearest_unvisited_point_walk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  nupw_pkg::in_t                        in_i,
  output logic                                 res_valid_o,
  output nupw_pkg::out_t                       res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nupw_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [nupw_pkg::CfgDataW-1:0]        cfg_data_i
);
  import nupw_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StSqrt  = 3'd4;
  localparam logic [2:0] StCmp   = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  // memories
  logic [CoordW-1:0] mem_x [MaxPoints];
  logic [CoordW-1:0] mem_y [MaxPoints];
  logic              mem_v [MaxPoints];
  logic [CoordW-1:0] rd_x_q, rd_y_q;
  logic              rd_v_q;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [CntW-1:0]   pcount_q;
  logic [PenW-1:0]   pen_q;
  logic [LimW-1:0]   limit_q;
  logic [CoordW-1:0] head_x_q, head_x_d, head_y_q, head_y_d;
  logic [LimW-1:0]   best_q, best_d;
  logic              have_q, have_d;
  logic [IdxW-1:0]   pick_q, pick_d;
  logic [CoordW-1:0] best_x_q, best_x_d, best_y_q, best_y_d;
  logic [CoordW-1:0] cand_x_q, cand_x_d, cand_y_q, cand_y_d;
  logic              right_q, right_d;
  // shared square-root unit
  logic [RootW-1:0]  rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [StepW-1:0]  step_q, step_d;

  logic              accept;
  logic [CoordW-1:0] dx, dy;
  logic [SumW-1:0]   sq_sum;
  logic [RootW-1:0]  trial;
  logic [LimW-1:0]   cost;
  logic [CntW-1:0]   idx_nxt;
  logic              vis_we;
  logic [IdxW-1:0]   vis_addr;
  logic              vis_data;

  assign busy_o      = (state_q != StIdle);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign dx      = (rd_x_q > head_x_q) ? rd_x_q - head_x_q : head_x_q - rd_x_q;
  assign dy      = (rd_y_q > head_y_q) ? rd_y_q - head_y_q : head_y_q - rd_y_q;
  assign sq_sum  = SumW'(dx) * SumW'(dx) + SumW'(dy) * SumW'(dy);
  assign trial   = root_q + bit_q;
  assign cost    = LimW'(root_q) + (right_q ? LimW'(pen_q) : LimW'(0));
  assign idx_nxt = idx_q + CntW'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    n_d      = n_q;
    head_x_d = head_x_q;
    head_y_d = head_y_q;
    best_d   = best_q;
    have_d   = have_q;
    pick_d   = pick_q;
    best_x_d = best_x_q;
    best_y_d = best_y_q;
    cand_x_d = cand_x_q;
    cand_y_d = cand_y_q;
    right_d  = right_q;
    rem_d    = rem_q;
    root_d   = root_q;
    bit_d    = bit_q;
    step_d   = step_q;
    vis_we   = 1'b0;
    vis_addr = idx_q[IdxW-1:0];
    vis_data = 1'b0;
    case (state_q)
      StClear: begin
        vis_we = 1'b1;
        idx_d  = idx_nxt;
        if (idx_nxt == CntW'(MaxPoints)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          case (in_i.action)
            ActStart: begin
              head_x_d = in_i.coord_x;
              head_y_d = in_i.coord_y;
              idx_d    = '0;
              state_d  = StClear;
            end
            ActAdvance: begin
              idx_d   = '0;
              n_d     = (pcount_q > CntW'(MaxPoints)) ? CntW'(MaxPoints) : pcount_q;
              best_d  = limit_q;
              have_d  = 1'b0;
              pick_d  = '0;
              state_d = (pcount_q == '0) ? StFin : StRead;
            end
            default: ;
          endcase
        end
      end
      StRead: state_d = StMul;
      StMul: begin
        if (rd_v_q) begin
          idx_d   = idx_nxt;
          state_d = (idx_nxt == n_q) ? StFin : StRead;
        end else begin
          cand_x_d = rd_x_q;
          cand_y_d = rd_y_q;
          right_d  = rd_x_q > head_x_q;
          rem_d    = RootW'(sq_sum);
          root_d   = '0;
          bit_d    = RootW'(1) << (2 * (SqrtSteps - 1));
          step_d   = StepW'(SqrtSteps - 1);
          state_d  = StSqrt;
        end
      end
      StSqrt: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (cost < best_q) begin
          best_d   = cost;
          have_d   = 1'b1;
          pick_d   = idx_q[IdxW-1:0];
          best_x_d = cand_x_q;
          best_y_d = cand_y_q;
        end
        idx_d   = idx_nxt;
        state_d = (idx_nxt == n_q) ? StFin : StRead;
      end
      StFin: begin
        if (have_q) begin
          vis_we   = 1'b1;
          vis_addr = pick_q;
          vis_data = 1'b1;
          head_x_d = best_x_q;
          head_y_d = best_y_q;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // result beat straight from the scan registers during the final cycle
  assign res_valid_o           = (state_q == StFin);
  assign res_o.found           = have_q;
  assign res_o.chosen_index    = have_q ? pick_q : '0;
  assign res_o.chosen_x        = have_q ? best_x_q : head_x_q;
  assign res_o.chosen_y        = have_q ? best_y_q : head_y_q;
  assign res_o.chosen_distance = have_q ? best_q[DistW-1:0] : '0;

  // point table and visited map
  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == ActLoad) begin
      mem_x[in_i.slot] <= in_i.coord_x;
      mem_y[in_i.slot] <= in_i.coord_y;
    end
    rd_x_q <= mem_x[idx_q[IdxW-1:0]];
    rd_y_q <= mem_y[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      mem_v[vis_addr] <= vis_data;
    end
    rd_v_q <= mem_v[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      idx_q    <= '0;
      n_q      <= '0;
      pcount_q <= RstPointCount;
      pen_q    <= RstPenalty;
      limit_q  <= RstLimit;
      head_x_q <= '0;
      head_y_q <= '0;
      have_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      head_x_q <= head_x_d;
      head_y_q <= head_y_d;
      have_q   <= have_d;
      step_q   <= step_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgPointCount: pcount_q <= cfg_data_i[CntW-1:0];
          CfgPenalty:    pen_q    <= cfg_data_i[PenW-1:0];
          CfgLimit:      limit_q  <= cfg_data_i[LimW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    pick_q   <= pick_d;
    best_x_q <= best_x_d;
    best_y_q <= best_y_d;
    cand_x_q <= cand_x_d;
    cand_y_q <= cand_y_d;
    right_q  <= right_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    bit_q    <= bit_d;
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the nearest unvisited point walk.
`timescale 1ns / 100ps

module testbench;
  import nupw_pkg::*;

  // Rising edge at 10 ns, period 20 ns.
  logic clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  in_t                 in_i        = '0;
  logic                res_valid_o;
  out_t                res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgPointCount;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  nearest_unvisited_point_walk u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Walk model: own copy of the point table, visited map, head and registers
  // ---------------------------------------------------------------------
  logic [CoordW-1:0] pt_x [MaxPoints];
  logic [CoordW-1:0] pt_y [MaxPoints];
  bit                pt_loaded [MaxPoints];
  bit                pt_visited [MaxPoints];
  logic [CoordW-1:0] head_x, head_y;
  logic [CntW-1:0]   n_points  = RstPointCount;
  logic [PenW-1:0]   right_pen = RstPenalty;
  logic [LimW-1:0]   dist_lim  = RstLimit;

  out_t pending_hops [$];   // expected result beats, oldest first
  int   n_errors = 0;
  bit   no_idle  = 1'b0;

  // floor of the exact square root, bit by bit from the top
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r, t;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Apply one accepted command; returns 1 with the hop when a result is due.
  function automatic bit walk_step(input in_t cmd, output out_t hop);
    int unsigned n, best, cost, dx, dy, pick;
    bit          have;
    hop = '0;
    case (cmd.action)
      ActLoad: begin
        pt_x[cmd.slot]      = cmd.coord_x;
        pt_y[cmd.slot]      = cmd.coord_y;
        pt_loaded[cmd.slot] = 1'b1;
        return 1'b0;
      end
      ActStart: begin
        head_x = cmd.coord_x;
        head_y = cmd.coord_y;
        foreach (pt_visited[i]) pt_visited[i] = 1'b0;
        return 1'b0;
      end
      ActAdvance: begin
        n    = (n_points > MaxPoints) ? MaxPoints : n_points;
        best = dist_lim;
        have = 1'b0;
        pick = 0;
        for (int i = 0; i < n; i++) begin
          if (pt_visited[i]) continue;
          if (!pt_loaded[i]) $display("testbench: stimulus reads unloaded slot %0d", i);
          dx   = (pt_x[i] > head_x) ? pt_x[i] - head_x : head_x - pt_x[i];
          dy   = (pt_y[i] > head_y) ? pt_y[i] - head_y : head_y - pt_y[i];
          cost = floor_root(dx * dx + dy * dy);
          if (pt_x[i] > head_x) cost += right_pen;
          if (cost < best) begin
            best = cost;
            pick = i;
            have = 1'b1;
          end
        end
        if (have) begin
          pt_visited[pick]    = 1'b1;
          head_x              = pt_x[pick];
          head_y              = pt_y[pick];
          hop.found           = 1'b1;
          hop.chosen_index    = pick[IdxW-1:0];
          hop.chosen_distance = best[DistW-1:0];
        end
        hop.chosen_x = head_x;
        hop.chosen_y = head_y;
        return 1'b1;
      end
      default: return 1'b0;   // unused code, ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending hop
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_hops.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("testbench: unexpected result beat %p", res_o);
      end else begin
        want = pending_hops.pop_front();
        if (res_o.found !== want.found || res_o.chosen_index !== want.chosen_index ||
            res_o.chosen_x !== want.chosen_x || res_o.chosen_y !== want.chosen_y ||
            res_o.chosen_distance !== want.chosen_distance) begin
          n_errors++;
          if (n_errors <= 10)
            $display("testbench: result mismatch, expected %p, got %p", want, res_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers (inputs move on the falling edge, handshakes seen on the rising)
  // ---------------------------------------------------------------------

  // Issue one command beat. start_i stays high afterwards so back-to-back
  // beats need no drop; an idle gap in a later call, or drain(), lowers it.
  // With use_typed set the hand-written hop is expected instead of the model's.
  task automatic send_cmd(input in_t cmd, input bit use_typed = 1'b0,
                          input out_t typed = '0);
    out_t hop;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 31) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i = 1'b1;
    in_i    = cmd;
    do @(posedge clk_i); while (busy_o);
    if (walk_step(cmd, hop)) pending_hops = {pending_hops, (use_typed ? typed : hop)};
  endtask

  // Let every pending hop arrive and the block go quiet (covers start sweeps).
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    do @(posedge clk_i); while (pending_hops.size() != 0 || busy_o);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgPointCount: n_points  = val[CntW-1:0];
      CfgPenalty:    right_pen = val[PenW-1:0];
      default:       dist_lim  = val[LimW-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic in_t mk(input logic [1:0] act, input int unsigned slot,
                             input int unsigned x, input int unsigned y);
    in_t c;
    c.action  = act;
    c.slot    = slot[IdxW-1:0];
    c.coord_x = x[CoordW-1:0];
    c.coord_y = y[CoordW-1:0];
    return c;
  endfunction

  function automatic out_t hop_of(input bit f, input int unsigned idx, input int unsigned x,
                                  input int unsigned y, input int unsigned d);
    out_t h;
    h.found           = f;
    h.chosen_index    = idx[IdxW-1:0];
    h.chosen_x        = x[CoordW-1:0];
    h.chosen_y        = y[CoordW-1:0];
    h.chosen_distance = d[DistW-1:0];
    return h;
  endfunction

  // Directed table: command, whether a hand-written hop applies, the hop.
  typedef struct {
    in_t  cmd;
    bit   typed;
    out_t want;
  } dir_row_t;

  dir_row_t dir_tab [$];

  function automatic void add_row(input in_t cmd, input bit typed = 1'b0,
                                  input out_t want = '0);
    dir_row_t r;
    r.cmd   = cmd;
    r.typed = typed;
    r.want  = want;
    dir_tab = {dir_tab, r};
  endfunction

  // random coordinate: full range most of the time, else a tight cluster
  function automatic int unsigned rand_coord();
    return ($urandom_range(99) < 60) ? $urandom_range(2047) : $urandom_range(600, 760);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int unsigned n_cmds, burst;
    logic [1:0]  act;
    head_x = '0;
    head_y = '0;
    foreach (pt_loaded[i]) begin
      pt_loaded[i]  = 1'b0;
      pt_visited[i] = 1'b0;
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    drain();   // also waits out the clearing sweep after reset

    // empty scan: zero entries, nothing qualifies, head still at the origin
    write_reg(CfgPointCount, 0);
    send_cmd(mk(ActAdvance, 0, 0, 0), 1'b1, hop_of(0, 0, 0, 0, 0));
    drain();
    write_reg(CfgPointCount, 8);

    // directed: corners, centre, a short hop, an ignored code
    add_row(mk(ActLoad, 0, 0, 0));
    add_row(mk(ActLoad, 1, 2047, 2047));
    add_row(mk(ActLoad, 2, 2047, 0));
    add_row(mk(ActLoad, 3, 0, 2047));
    add_row(mk(ActLoad, 4, 1024, 1024));
    add_row(mk(ActLoad, 5, 3, 4));
    add_row(mk(ActLoad, 6, 1365, 682));
    add_row(mk(ActLoad, 7, 682, 1365));
    add_row(mk(ActStart, 0, 0, 0));
    add_row(mk(ActAdvance, 0, 0, 0), 1'b1, hop_of(1, 0, 0, 0, 0));
    add_row(mk(ActAdvance, 0, 0, 0));
    add_row(mk(2'd3, 1023, 2047, 2047));
    add_row(mk(ActAdvance, 0, 0, 0));
    add_row(mk(ActAdvance, 0, 0, 0));
    add_row(mk(ActStart, 0, 2047, 2047));
    add_row(mk(ActAdvance, 0, 0, 0), 1'b1, hop_of(1, 1, 2047, 2047, 0));
    add_row(mk(ActAdvance, 0, 0, 0));
    add_row(mk(ActAdvance, 0, 0, 0));
    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);

    // fill slots up to 63 so any small point count reads loaded entries only
    for (int s = 8; s < 64; s++) send_cmd(mk(ActLoad, s, rand_coord(), rand_coord()));
    n_cmds = 56;

    // random phases: fresh registers, then mostly start + advances
    while (n_cmds < 500) begin
      drain();   // also the pause until every pending hop is in
      write_reg(CfgPointCount, $urandom_range(1, 64));
      case ($urandom_range(3))
        0:       write_reg(CfgPenalty, 0);
        1:       write_reg(CfgPenalty, 255);
        default: write_reg(CfgPenalty, $urandom_range(255));
      endcase
      case ($urandom_range(9))
        0:       write_reg(CfgLimit, 0);
        1:       write_reg(CfgLimit, 16383);
        2, 3:    write_reg(CfgLimit, $urandom_range(400));
        default: write_reg(CfgLimit, $urandom_range(16383));
      endcase
      no_idle = (n_cmds >= 200 && n_cmds < 320);
      if ($urandom_range(99) < 85) begin
        send_cmd(mk(ActStart, 0, rand_coord(), rand_coord()));
        n_cmds++;
      end
      burst = $urandom_range(5, 20);
      repeat (burst) begin
        case ($urandom_range(9))
          0, 1:    act = ActLoad;
          2:       act = 2'd3;
          default: act = ActAdvance;
        endcase
        if (act == ActLoad)
          send_cmd(mk(ActLoad, ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                         : $urandom_range(63),
                      rand_coord(), rand_coord()));
        else
          send_cmd(mk(act, $urandom_range(1023), $urandom_range(2047), $urandom_range(2047)));
        n_cmds++;
      end
    end
    no_idle = 1'b0;

    // loaded part of the table with extreme penalty and limit
    drain();
    write_reg(CfgPointCount, 64);
    write_reg(CfgPenalty, 255);
    write_reg(CfgLimit, 16383);
    send_cmd(mk(ActStart, 0, 1024, 1024));
    repeat (3) send_cmd(mk(ActAdvance, 0, 0, 0));
    drain();
    write_reg(CfgPenalty, 0);
    repeat (2) send_cmd(mk(ActAdvance, 0, 0, 0));

    drain();
    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && pending_hops.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
